>>> hdl/itp_pkg.sv
// Shared types, codes and the precedence function for the infix-to-postfix converter.
`timescale 1ns / 1ps

package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    // Input token kinds
    localparam logic [2:0] TOK_NUM    = 3'd0;
    localparam logic [2:0] TOK_OP     = 3'd1;
    localparam logic [2:0] TOK_LPAREN = 3'd2;
    localparam logic [2:0] TOK_RPAREN = 3'd3;
    localparam logic [2:0] TOK_FUNC   = 3'd4;
    localparam logic [2:0] TOK_END    = 3'd5;
    localparam logic [2:0] TOK_NONE   = 3'd7;

    // Operator codes
    localparam logic [2:0] OP_PLUS  = 3'd0;
    localparam logic [2:0] OP_MINUS = 3'd1;
    localparam logic [2:0] OP_TIMES = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_POWER = 3'd4;

    // Stack entry kinds
    localparam logic [1:0] ENT_OP     = 2'd0;
    localparam logic [1:0] ENT_LPAREN = 2'd1;
    localparam logic [1:0] ENT_FUNC   = 2'd2;

    // Result kinds
    localparam logic [2:0] OUT_NUM    = 3'd0;
    localparam logic [2:0] OUT_OP     = 3'd1;
    localparam logic [2:0] OUT_LPAREN = 3'd2;
    localparam logic [2:0] OUT_FUNC   = 3'd3;
    localparam logic [2:0] OUT_END    = 3'd4;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] code;
    } entry_t;

    typedef struct packed {
        logic        imp;
        logic [2:0]  kind;
        logic [2:0]  op;
        logic [3:0]  fn;
        logic [63:0] value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  op;
        logic [3:0]  fn;
        logic [63:0] value;
        logic        ovf;
    } result_t;

    function automatic logic [1:0] prec(input logic [2:0] op);
        case (op)
            OP_POWER:          prec = 2'd3;
            OP_TIMES, OP_DIV:  prec = 2'd2;
            OP_PLUS, OP_MINUS: prec = 2'd1;
            default:           prec = 2'd0;
        endcase
    endfunction

endpackage

>>> hdl/itp_cmd_fifo.sv
// Two-entry command queue between the token front end and the stack engine.
`timescale 1ns / 1ps

module itp_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  itp_pkg::cmd_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output itp_pkg::cmd_t rd_data
);

    itp_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          wr_fire, rd_fire;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_fire ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_fire ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire && !rd_fire) begin
            count_next = count_reg + 2'd1;
        end else if (!wr_fire && rd_fire) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (wr_fire) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hdl/itp_front.sv
// Token front end: accepts words, tracks the previous kind and flags implicit multiplication.
`timescale 1ns / 1ps

module itp_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [2:0]    s_token_kind,
    input  logic [2:0]    s_operator_code,
    input  logic [3:0]    s_function_code,
    input  logic [63:0]   s_number_value,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output itp_pkg::cmd_t cmd_data
);

    logic [2:0] prev_kind_reg, prev_kind_next;
    logic       accept;
    logic       known_kind;
    logic       imp;

    assign s_ready    = cmd_ready;
    assign accept     = s_valid && s_ready;
    assign known_kind = (s_token_kind <= itp_pkg::TOK_END);
    // Drop words with unknown kinds without touching any state
    assign cmd_valid  = s_valid && known_kind;

    always_comb begin
        imp = 1'b0;
        if (prev_kind_reg == itp_pkg::TOK_NUM) begin
            imp = s_token_kind inside {itp_pkg::TOK_LPAREN, itp_pkg::TOK_FUNC};
        end else if (prev_kind_reg == itp_pkg::TOK_RPAREN) begin
            imp = s_token_kind inside {itp_pkg::TOK_NUM, itp_pkg::TOK_FUNC,
                                       itp_pkg::TOK_LPAREN};
        end
        cmd_data.imp   = imp;
        cmd_data.kind  = s_token_kind;
        cmd_data.op    = s_operator_code;
        cmd_data.fn    = s_function_code;
        cmd_data.value = s_number_value;

        prev_kind_next = prev_kind_reg;
        if (accept && known_kind) begin
            prev_kind_next = (s_token_kind == itp_pkg::TOK_END) ? itp_pkg::TOK_NONE
                                                                 : s_token_kind;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_kind_reg <= itp_pkg::TOK_NONE;
        end else begin
            prev_kind_reg <= prev_kind_next;
        end
    end

endmodule

>>> hdl/itp_back.sv
// Stack engine: runs the shunting-yard steps, one push or pop per cycle unless stalled, and emits words.
`timescale 1ns / 1ps

module itp_back #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  itp_pkg::cmd_t cmd_data,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_out_kind,
    output logic [2:0]    m_out_operator,
    output logic [3:0]    m_out_function,
    output logic [63:0]   m_out_value,
    output logic          m_overflow_seen,
    output logic          m_last
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_IMP,
        ST_TOK,
        ST_RFN
    } state_t;

    state_t                state_reg, state_next;
    itp_pkg::cmd_t         cmd_reg, cmd_next;
    itp_pkg::entry_t       top_reg, top_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    itp_pkg::result_t      hold_reg, hold_next;
    logic                  hold_valid_reg, hold_valid_next;
    logic                  hold_last_reg, hold_last_next;
    itp_pkg::result_t      out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_last_reg, out_last_next;

    // Entries below the top live in memory; top_reg caches the top
    itp_pkg::entry_t       mem [STACK_DEPTH];
    itp_pkg::entry_t       rd_reg;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [CW-1:0]         rd_pos;

    logic                  emit, done, do_push, do_pop, ovf_clr;
    logic                  stall, adv, can_move, move_hold;
    itp_pkg::result_t      res, pop_res;
    itp_pkg::entry_t       push_ent;
    logic [2:0]            op_sel;
    logic                  nonempty, top_is_op, pops_op;
    logic [1:0]            p_new, p_top;

    assign can_move  = !out_valid_reg || m_ready;
    assign nonempty  = (count_reg != '0);
    assign top_is_op = nonempty && (top_reg.kind == itp_pkg::ENT_OP);
    assign op_sel    = (state_reg == ST_IMP) ? itp_pkg::OP_TIMES : cmd_reg.op;
    assign p_new     = itp_pkg::prec(op_sel);
    assign p_top     = itp_pkg::prec(top_reg.code[2:0]);
    assign pops_op   = top_is_op &&
                       ((p_top > p_new) || (p_top == p_new && op_sel != itp_pkg::OP_POWER));

    always_comb begin
        pop_res       = '0;
        pop_res.kind  = itp_pkg::OUT_FUNC;
        pop_res.fn    = top_reg.code;
        if (top_reg.kind == itp_pkg::ENT_OP) begin
            pop_res.kind = itp_pkg::OUT_OP;
            pop_res.op   = top_reg.code[2:0];
            pop_res.fn   = 4'd0;
        end else if (top_reg.kind == itp_pkg::ENT_LPAREN) begin
            pop_res.kind = itp_pkg::OUT_LPAREN;
            pop_res.fn   = 4'd0;
        end
    end

    // Sequencer: decide this cycle's stack action and result
    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cmd_ready  = 1'b0;
        emit       = 1'b0;
        done       = 1'b0;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        ovf_clr    = 1'b0;
        res        = pop_res;
        push_ent   = '0;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_ready  = 1'b1;
                    cmd_next   = cmd_data;
                    state_next = cmd_data.imp ? ST_IMP : ST_TOK;
                end
            end
            ST_IMP: begin
                if (pops_op) begin
                    emit   = 1'b1;
                    do_pop = 1'b1;
                end else begin
                    do_push       = 1'b1;
                    push_ent.kind = itp_pkg::ENT_OP;
                    push_ent.code = {1'b0, itp_pkg::OP_TIMES};
                    state_next    = ST_TOK;
                end
            end
            ST_TOK: begin
                case (cmd_reg.kind)
                    itp_pkg::TOK_NUM: begin
                        emit       = 1'b1;
                        res        = '0;
                        res.kind   = itp_pkg::OUT_NUM;
                        res.value  = cmd_reg.value;
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    itp_pkg::TOK_OP: begin
                        if (pops_op) begin
                            emit   = 1'b1;
                            do_pop = 1'b1;
                        end else begin
                            do_push       = 1'b1;
                            push_ent.kind = itp_pkg::ENT_OP;
                            push_ent.code = {1'b0, cmd_reg.op};
                            done          = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    itp_pkg::TOK_LPAREN: begin
                        do_push       = 1'b1;
                        push_ent.kind = itp_pkg::ENT_LPAREN;
                        done          = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    itp_pkg::TOK_RPAREN: begin
                        if (nonempty && top_reg.kind != itp_pkg::ENT_LPAREN) begin
                            emit   = 1'b1;
                            do_pop = 1'b1;
                        end else if (nonempty) begin
                            // drop the matching left paren, then check for a function
                            do_pop     = 1'b1;
                            state_next = ST_RFN;
                        end else begin
                            done       = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    itp_pkg::TOK_FUNC: begin
                        do_push       = 1'b1;
                        push_ent.kind = itp_pkg::ENT_FUNC;
                        push_ent.code = cmd_reg.fn;
                        done          = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    default: begin
                        if (nonempty) begin
                            emit   = 1'b1;
                            do_pop = 1'b1;
                        end else begin
                            emit       = 1'b1;
                            res        = '0;
                            res.kind   = itp_pkg::OUT_END;
                            res.ovf    = ovf_reg;
                            ovf_clr    = 1'b1;
                            done       = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_RFN: begin
                if (nonempty && top_reg.kind == itp_pkg::ENT_FUNC) begin
                    emit   = 1'b1;
                    do_pop = 1'b1;
                end
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold off when a new result needs the holding slot and the output is blocked
    assign stall     = emit && hold_valid_reg && !can_move;
    assign adv       = !stall;
    assign move_hold = hold_valid_reg && can_move && (hold_last_reg || (emit && adv));

    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        ovf_next   = ovf_reg;
        wr_en      = 1'b0;
        wr_addr    = AW'(count_reg - CW'(1));
        if (adv && do_push) begin
            if (count_reg < CW'(STACK_DEPTH)) begin
                wr_en      = nonempty;
                top_next   = push_ent;
                count_next = count_reg + CW'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end else if (adv && do_pop) begin
            top_next   = rd_reg;
            count_next = count_reg - CW'(1);
        end
        if (adv && ovf_clr) begin
            ovf_next = 1'b0;
        end
        // Keep the entry just below the next top prefetched
        rd_pos  = (count_next >= CW'(2)) ? (count_next - CW'(2)) : '0;
        rd_addr = rd_pos[AW-1:0];
    end

    always_comb begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        hold_last_next  = hold_last_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        if (move_hold) begin
            out_next       = hold_reg;
            out_last_next  = hold_last_reg;
            out_valid_next = 1'b1;
        end
        if (emit && adv) begin
            hold_next       = res;
            hold_valid_next = 1'b1;
            hold_last_next  = done;
        end else if (move_hold) begin
            hold_valid_next = 1'b0;
        end else if (done && adv && hold_valid_reg) begin
            hold_last_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end else begin
            state_reg      <= adv ? state_next : state_reg;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            hold_valid_reg <= hold_valid_next;
            hold_last_reg  <= hold_last_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
        end
        cmd_reg  <= cmd_next;
        top_reg  <= top_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= top_reg;
        end
        if (wr_en && wr_addr == rd_addr) begin
            rd_reg <= top_reg;
        end else begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_kind      = out_reg.kind;
    assign m_out_operator  = out_reg.op;
    assign m_out_function  = out_reg.fn;
    assign m_out_value     = out_reg.value;
    assign m_overflow_seen = out_reg.ovf;
    assign m_last          = out_last_reg;

endmodule

>>> hdl/infix_to_postfix_converter.sv
// Top level of the infix-to-postfix converter: front end, command queue and stack engine.
`timescale 1ns / 1ps

// Takes lexed tokens one word at a time and returns them in postfix order,
// inserting a times operator where juxtaposition implies one. The front end
// classifies each word in the cycle it is accepted and queues it (two
// entries). The stack engine then takes the command and, while it is not
// stalled, does one push or pop per cycle after that. A number goes straight
// out; a left paren or function is pushed. An implicit times or an operator
// first pops the operators it displaces and is then pushed. A right paren
// that finds its left paren pops the operators above it and drops the left
// paren; the enclosing function, if any, goes out last. A right paren that
// finds none pops every entry. An end token pops every pending entry and then
// emits the end word. Each result waits in a holding stage until it is known
// whether it is the last word for its token, then passes to the output
// register. A blocked output stalls the engine only when a new result meets a
// full holding stage. STACK_DEPTH sets the pending stack size; a push onto a
// full stack is dropped and reported on the next end marker through
// m_overflow_seen.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_token_kind,
    input  logic [2:0]  s_operator_code,
    input  logic [3:0]  s_function_code,
    input  logic [63:0] s_number_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_kind,
    output logic [2:0]  m_out_operator,
    output logic [3:0]  m_out_function,
    output logic [63:0] m_out_value,
    output logic        m_overflow_seen,
    output logic        m_last
);

    logic          fq_valid, fq_ready;
    itp_pkg::cmd_t fq_data;
    logic          bq_valid, bq_ready;
    itp_pkg::cmd_t bq_data;

    itp_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_token_kind    (s_token_kind),
        .s_operator_code (s_operator_code),
        .s_function_code (s_function_code),
        .s_number_value  (s_number_value),
        .cmd_valid       (fq_valid),
        .cmd_ready       (fq_ready),
        .cmd_data        (fq_data)
    );

    itp_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (bq_valid),
        .rd_ready (bq_ready),
        .rd_data  (bq_data)
    );

    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (bq_valid),
        .cmd_ready       (bq_ready),
        .cmd_data        (bq_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_kind      (m_out_kind),
        .m_out_operator  (m_out_operator),
        .m_out_function  (m_out_function),
        .m_out_value     (m_out_value),
        .m_overflow_seen (m_overflow_seen),
        .m_last          (m_last)
    );

endmodule

>>> tb/tb_infix_to_postfix_converter.sv
// Self-checking testbench for the infix-to-postfix converter: directed table, then random
// tokens, stack fills and expressions checked against a shunting-yard predictor.
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter;

    localparam int STACK_SLOTS = itp_pkg::STACK_DEPTH_DEF;

    // Codes the package leaves unnamed
    localparam logic [2:0] OP_OTHER   = 3'd5;
    localparam logic [2:0] OP_SPARE6  = 3'd6;
    localparam logic [2:0] OP_SPARE7  = 3'd7;
    localparam logic [2:0] TOK_SPARE6 = 3'd6;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  op;
        logic [3:0]  fn;
        logic [63:0] value;
        logic        ovf;
        logic        last;
    } postfix_word_t;

    typedef struct packed {
        logic [2:0]    kind;
        logic [2:0]    op;
        logic [3:0]    fn;
        logic [63:0]   value;
        logic          typed;
        postfix_word_t want;
    } token_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_token_kind;
    logic [2:0]  s_operator_code;
    logic [3:0]  s_function_code;
    logic [63:0] s_number_value;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_out_kind;
    logic [2:0]  m_out_operator;
    logic [3:0]  m_out_function;
    logic [63:0] m_out_value;
    logic        m_overflow_seen;
    logic        m_last;

    // Predictor state
    itp_pkg::entry_t pend_stack [STACK_SLOTS];
    int              pend_count;
    logic [2:0]      prev_tok;
    logic            ovf_pending;
    postfix_word_t   step_words[$];
    postfix_word_t   expected_words[$];

    token_row_t    token_script[$];
    int            items_sent;
    int            words_checked;
    int            error_count;
    bit            calm;

    infix_to_postfix_converter #(
        .STACK_DEPTH(STACK_SLOTS)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_token_kind(s_token_kind),
        .s_operator_code(s_operator_code),
        .s_function_code(s_function_code),
        .s_number_value(s_number_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_kind(m_out_kind),
        .m_out_operator(m_out_operator),
        .m_out_function(m_out_function),
        .m_out_value(m_out_value),
        .m_overflow_seen(m_overflow_seen),
        .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("tb_infix_to_postfix_converter failed");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic int op_rank(input logic [2:0] op);
        case (op)
            itp_pkg::OP_POWER:                   op_rank = 3;
            itp_pkg::OP_TIMES, itp_pkg::OP_DIV:  op_rank = 2;
            itp_pkg::OP_PLUS, itp_pkg::OP_MINUS: op_rank = 1;
            default:                             op_rank = 0;
        endcase
    endfunction

    task automatic put_word(input logic [2:0] kind, input logic [2:0] op, input logic [3:0] fn,
                            input logic [63:0] value, input logic ovf);
        postfix_word_t w;
        w.kind  = kind;
        w.op    = op;
        w.fn    = fn;
        w.value = value;
        w.ovf   = ovf;
        w.last  = 1'b0;
        step_words.insert(step_words.size(), w);
    endtask

    task automatic pop_entry();
        itp_pkg::entry_t e;
        e = pend_stack[pend_count - 1];
        pend_count--;
        case (e.kind)
            itp_pkg::ENT_OP:     put_word(itp_pkg::OUT_OP, e.code[2:0], '0, '0, 1'b0);
            itp_pkg::ENT_LPAREN: put_word(itp_pkg::OUT_LPAREN, '0, '0, '0, 1'b0);
            default:             put_word(itp_pkg::OUT_FUNC, '0, e.code, '0, 1'b0);
        endcase
    endtask

    task automatic push_entry(input logic [1:0] kind, input logic [3:0] code);
        if (pend_count >= STACK_SLOTS) begin
            ovf_pending = 1'b1;   // drop, remember for the end marker
        end else begin
            pend_stack[pend_count] = {kind, code};
            pend_count++;
        end
    endtask

    task automatic apply_operator(input logic [2:0] op);
        int  rank;
        int  top_rank;
        bit  done;
        rank = op_rank(op);
        done = 1'b0;
        while (!done && pend_count > 0 &&
               pend_stack[pend_count - 1].kind == itp_pkg::ENT_OP) begin
            top_rank = op_rank(pend_stack[pend_count - 1].code[2:0]);
            // power binds to the right: equal rank does not pop it
            if (top_rank > rank || (top_rank == rank && op != itp_pkg::OP_POWER)) pop_entry();
            else done = 1'b1;
        end
        push_entry(itp_pkg::ENT_OP, {1'b0, op});
    endtask

    task automatic convert_token(input logic [2:0] kind, input logic [2:0] op,
                                 input logic [3:0] fn, input logic [63:0] value);
        postfix_word_t w;
        step_words.delete();
        if (kind <= itp_pkg::TOK_END) begin
            // juxtaposition implies a times operator
            if ((prev_tok == itp_pkg::TOK_NUM &&
                 (kind == itp_pkg::TOK_LPAREN || kind == itp_pkg::TOK_FUNC)) ||
                (prev_tok == itp_pkg::TOK_RPAREN &&
                 (kind == itp_pkg::TOK_NUM || kind == itp_pkg::TOK_FUNC ||
                  kind == itp_pkg::TOK_LPAREN)))
                apply_operator(itp_pkg::OP_TIMES);
            case (kind)
                itp_pkg::TOK_NUM:    put_word(itp_pkg::OUT_NUM, '0, '0, value, 1'b0);
                itp_pkg::TOK_OP:     apply_operator(op);
                itp_pkg::TOK_LPAREN: push_entry(itp_pkg::ENT_LPAREN, '0);
                itp_pkg::TOK_RPAREN: begin
                    while (pend_count > 0 &&
                           pend_stack[pend_count - 1].kind != itp_pkg::ENT_LPAREN)
                        pop_entry();
                    if (pend_count > 0) pend_count--;
                    if (pend_count > 0 && pend_stack[pend_count - 1].kind == itp_pkg::ENT_FUNC)
                        pop_entry();
                end
                itp_pkg::TOK_FUNC:   push_entry(itp_pkg::ENT_FUNC, fn);
                default: begin
                    while (pend_count > 0) pop_entry();
                    put_word(itp_pkg::OUT_END, '0, '0, '0, ovf_pending);
                    ovf_pending = 1'b0;
                end
            endcase
            prev_tok = (kind == itp_pkg::TOK_END) ? itp_pkg::TOK_NONE : kind;
            if (step_words.size() > 0) begin
                w = step_words[step_words.size() - 1];
                w.last = 1'b1;
                step_words[step_words.size() - 1] = w;
            end
        end
    endtask

    // ---------------- stimulus ----------------

    function automatic logic [63:0] rand_value();
        logic [31:0] r;
        r = $urandom_range(0, 9);
        if (r == 0) rand_value = '0;
        else if (r == 1) rand_value = '1;
        else rand_value = {$urandom, $urandom};
    endfunction

    function automatic logic [2:0] rand_op();
        logic [31:0] r;
        if ($urandom_range(0, 9) < 8) r = $urandom_range(0, 4);
        else r = $urandom_range(5, 7);
        rand_op = r[2:0];
    endfunction

    task automatic add_row(input logic [2:0] kind, input logic [2:0] op, input logic [3:0] fn,
                           input logic [63:0] value, input logic typed,
                           input logic [2:0] want_kind, input logic [63:0] want_value);
        token_row_t row;
        row.kind  = kind;
        row.op    = op;
        row.fn    = fn;
        row.value = value;
        row.typed = typed;
        row.want  = '0;
        row.want.kind  = want_kind;
        row.want.value = want_value;
        row.want.last  = 1'b1;
        token_script.insert(token_script.size(), row);
    endtask

    task automatic send_token(input logic [2:0] kind, input logic [2:0] op, input logic [3:0] fn,
                              input logic [63:0] value, input logic typed,
                              input postfix_word_t want);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_token_kind    <= kind;
        s_operator_code <= op;
        s_function_code <= fn;
        s_number_value  <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        convert_token(kind, op, fn, value);
        if (typed) expected_words.insert(expected_words.size(), want);
        else foreach (step_words[i]) expected_words.insert(expected_words.size(), step_words[i]);
        if (kind <= itp_pkg::TOK_END) items_sent++;
    endtask

    task automatic send_random_token(input logic [2:0] kind);
        logic [31:0] r;
        r = $urandom_range(0, 15);
        send_token(kind, rand_op(), r[3:0], rand_value(), 1'b0, '0);
    endtask

    // Deep nesting of parens, functions and powers to run the stack past full
    task automatic fill_stack(input int n);
        logic [31:0] r;
        repeat (n) begin
            r = $urandom_range(0, 19);
            if (r < 10) send_random_token(itp_pkg::TOK_LPAREN);
            else if (r < 15) send_random_token(itp_pkg::TOK_FUNC);
            else if (r < 18)
                send_token(itp_pkg::TOK_OP, itp_pkg::OP_POWER, r[3:0], rand_value(), 1'b0, '0);
            else send_random_token(itp_pkg::TOK_NUM);
        end
        send_random_token(itp_pkg::TOK_END);
    endtask

    task automatic send_expression();
        int          operands;
        int          depth;
        bit          want_operand;
        bit          after_close;
        logic [31:0] r;
        operands     = $urandom_range(1, 8);
        depth        = 0;
        want_operand = 1'b1;
        after_close  = 1'b0;
        while (operands > 0 || want_operand) begin
            r = $urandom_range(0, 9);
            if (want_operand) begin
                if (r < 2 && depth < 6) begin
                    send_random_token(itp_pkg::TOK_LPAREN);
                    depth++;
                end else if (r == 2) begin
                    send_random_token(itp_pkg::TOK_FUNC);
                    send_random_token(itp_pkg::TOK_LPAREN);
                    depth++;
                end else begin
                    send_random_token(itp_pkg::TOK_NUM);
                    operands--;
                    want_operand = 1'b0;
                    after_close  = 1'b0;
                end
            end else if (r < 3 && depth > 0) begin
                send_random_token(itp_pkg::TOK_RPAREN);
                depth--;
                after_close = 1'b1;
            end else if (r == 3) begin
                // implicit product: operand followed by paren or function
                if ($urandom_range(0, 1) == 0) send_random_token(itp_pkg::TOK_FUNC);
                send_random_token(itp_pkg::TOK_LPAREN);
                depth++;
                want_operand = 1'b1;
            end else if (r == 4 && after_close) begin
                send_random_token(itp_pkg::TOK_NUM);
                operands--;
                after_close = 1'b0;
            end else begin
                send_random_token(itp_pkg::TOK_OP);
                want_operand = 1'b1;
            end
        end
        // leave a paren open now and then, or add a stray close
        while (depth > 0 && $urandom_range(0, 5) != 0) begin
            send_random_token(itp_pkg::TOK_RPAREN);
            depth--;
        end
        if ($urandom_range(0, 9) == 0) send_random_token(itp_pkg::TOK_RPAREN);
        send_random_token(itp_pkg::TOK_END);
    endtask

    // ---------------- result checking ----------------

    task automatic check_word();
        postfix_word_t want;
        words_checked++;
        if (expected_words.size() == 0) begin
            $error("result word with nothing expected: out_kind %0d", m_out_kind);
            error_count++;
        end else begin
            want = expected_words.pop_front();
            if (m_out_kind !== want.kind) begin
                $error("out_kind: expected %0d, got %0d", want.kind, m_out_kind);
                error_count++;
            end
            if (m_out_operator !== want.op) begin
                $error("out_operator: expected %0d, got %0d", want.op, m_out_operator);
                error_count++;
            end
            if (m_out_function !== want.fn) begin
                $error("out_function: expected %0d, got %0d", want.fn, m_out_function);
                error_count++;
            end
            if (m_out_value !== want.value) begin
                $error("out_value: expected %h, got %h", want.value, m_out_value);
                error_count++;
            end
            if (m_overflow_seen !== want.ovf) begin
                $error("overflow_seen: expected %0d, got %0d", want.ovf, m_overflow_seen);
                error_count++;
            end
            if (m_last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, m_last);
                error_count++;
            end
        end
    endtask

    initial begin : result_sink
        int stall_left;
        bit long_hold_done;
        bit ready_next;
        stall_left     = 0;
        long_hold_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) check_word();
            if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (!long_hold_done && words_checked >= 40) begin
                // long back-pressure so the input side fills up and stalls
                long_hold_done = 1'b1;
                stall_left     = 299;
                ready_next     = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 13);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_ready <= ready_next;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        int          target;
        logic [31:0] r;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_token_kind    <= itp_pkg::TOK_NUM;
        s_operator_code <= itp_pkg::OP_PLUS;
        s_function_code <= '0;
        s_number_value  <= '0;
        pend_count    = 0;
        prev_tok      = itp_pkg::TOK_NONE;
        ovf_pending   = 1'b0;
        items_sent    = 0;
        words_checked = 0;
        error_count   = 0;
        calm          = 1'b0;

        add_row(itp_pkg::TOK_END, itp_pkg::OP_PLUS, 4'h0, '0, 1'b1, itp_pkg::OUT_END, '0);
        add_row(itp_pkg::TOK_NUM, OP_SPARE7, 4'hf, '0, 1'b1, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_OP, itp_pkg::OP_MINUS, 4'h0, '1, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_NUM, itp_pkg::OP_PLUS, 4'h0, '1, 1'b1, itp_pkg::OUT_NUM, '1);
        // unmatched
        add_row(itp_pkg::TOK_RPAREN, itp_pkg::OP_PLUS, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_LPAREN, itp_pkg::OP_PLUS, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_NUM, itp_pkg::OP_POWER, 4'h3, 64'd2, 1'b1, itp_pkg::OUT_NUM, 64'd2);
        add_row(itp_pkg::TOK_OP, itp_pkg::OP_POWER, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_NUM, itp_pkg::OP_PLUS, 4'h0, 64'd3, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_OP, itp_pkg::OP_POWER, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_FUNC, itp_pkg::OP_PLUS, 4'hf, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_LPAREN, itp_pkg::OP_PLUS, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_OP, OP_OTHER, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_OP, OP_SPARE6, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_OP, itp_pkg::OP_PLUS, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(TOK_SPARE6, itp_pkg::OP_TIMES, 4'h5, '1, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_RPAREN, itp_pkg::OP_PLUS, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_RPAREN, itp_pkg::OP_PLUS, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_NUM, itp_pkg::OP_PLUS, 4'h0, 64'd4, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_FUNC, itp_pkg::OP_PLUS, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_LPAREN, itp_pkg::OP_PLUS, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_RPAREN, itp_pkg::OP_PLUS, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_FUNC, itp_pkg::OP_PLUS, 4'h9, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_OP, itp_pkg::OP_DIV, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_NUM, itp_pkg::OP_PLUS, 4'h0, 64'd7, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_LPAREN, itp_pkg::OP_PLUS, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_OP, OP_SPARE7, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_NONE, itp_pkg::OP_MINUS, 4'ha, '1, 1'b0, itp_pkg::OUT_NUM, '0);
        add_row(itp_pkg::TOK_END, itp_pkg::OP_PLUS, 4'h0, '0, 1'b0, itp_pkg::OUT_NUM, '0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (token_script[i])
            send_token(token_script[i].kind, token_script[i].op, token_script[i].fn,
                       token_script[i].value, token_script[i].typed, token_script[i].want);

        target = items_sent + 180;
        fill_stack($urandom_range(40, 48));
        while (items_sent < target) begin
            calm = (items_sent >= target - 40);
            r = $urandom_range(0, 19);
            if (r < 3) begin
                repeat ($urandom_range(1, 4)) begin
                    r = $urandom_range(0, 7);
                    send_random_token(r[2:0]);
                end
            end else if (r == 3) begin
                fill_stack($urandom_range(40, 48));
            end else begin
                send_expression();
            end
        end

        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (error_count == 0)
            $display("tb_infix_to_postfix_converter passed");
        else
            $display("tb_infix_to_postfix_converter failed");
        $finish;
    end

endmodule

>>> infix_to_postfix_converter.f
hdl/itp_pkg.sv
hdl/itp_cmd_fifo.sv
hdl/itp_front.sv
hdl/itp_back.sv
hdl/infix_to_postfix_converter.sv
tb/tb_infix_to_postfix_converter.sv
